[rtl/bfiq_pkg.sv]
`default_nettype none

package bfiq_pkg;

  localparam int WORDS_DEF      = 64;
  localparam int WORD_BITS_DEF  = 64;
  localparam int NUM_PROBES_DEF = 4;

  // probe index width and the serial remainder unit's grain
  localparam int IDX_W      = 64;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = IDX_W / DIV_STEPS;
  localparam int DIV_CW     = $clog2(DIV_CYCLES);

  localparam int FIFO_DEPTH = 2;

  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic             query;
    logic [IDX_W-1:0] key;
    logic [IDX_W-1:0] step;
  } bfiq_item_t;

  typedef struct packed {
    logic query;
    logic last;
  } bfiq_ctl_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic bit is_pow2(input int v);
    return (v & (v - 1)) == 0;
  endfunction

endpackage

`default_nettype wire

[rtl/bloom_filter_insert_query_top.sv]
`default_nettype none

// Bloom filter with double hashing. Each transaction on the in_ channel is an
// insert (in_func 0) or a membership query (in_func 1) carrying a primary hash
// and a stride hash; probe i tests or sets bit (key + step*i) of the filter,
// split into word and bit by WORD_BITS and wrapped over WORDS words. Inserts
// return nothing; each query returns one out_ transaction, in order. After
// reset the filter clears every word with in_ready low. With WORDS and
// WORD_BITS both powers of two, probes run one per cycle, while the output
// is not held, through the bit store (one read and one write port, with
// write forwarding); a query's result is registered after its last probe
// passes the mapper and data stage. Other sizes map one probe index at a
// time in a serial remainder unit, four index bits per cycle. A two-entry
// queue decouples input acceptance from probe execution.
module bloom_filter_insert_query_top import bfiq_pkg::*; #(
  parameter int WORDS      = WORDS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int NUM_PROBES = NUM_PROBES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_func,
  input  wire logic [IDX_W-1:0] in_key_hash,
  input  wire logic [IDX_W-1:0] in_step_hash,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_maybe_present
);

  logic       clear_busy;
  logic       push_valid, push_ready;
  bfiq_item_t push_item;
  logic       q_valid, q_ready;
  bfiq_item_t q_item;

  bfiq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (clear_busy),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_key_hash  (in_key_hash),
    .in_step_hash (in_step_hash),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  bfiq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  bfiq_back #(
    .WORDS      (WORDS),
    .WORD_BITS  (WORD_BITS),
    .NUM_PROBES (NUM_PROBES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (q_valid),
    .item_ready        (q_ready),
    .item              (q_item),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_maybe_present (out_maybe_present)
  );

endmodule

`default_nettype wire

[rtl/bfiq_front.sv]
`default_nettype none

module bfiq_front import bfiq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             hold,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_func,
  input  wire logic [IDX_W-1:0] in_key_hash,
  input  wire logic [IDX_W-1:0] in_step_hash,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output bfiq_item_t            push_item
);

  logic       valid_r, valid_nxt;
  bfiq_item_t item_r, item_nxt;
  logic       accept;

  assign in_ready   = !hold && (!valid_r || push_ready);
  assign accept     = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt      = 1'b1;
      item_nxt.query = (in_func == FUNC_QUERY);
      item_nxt.key   = in_key_hash;
      item_nxt.step  = in_step_hash;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

[rtl/bfiq_fifo.sv]
`default_nettype none

module bfiq_fifo import bfiq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_valid,
  output logic            wr_ready,
  input  wire bfiq_item_t wr_item,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output bfiq_item_t      rd_item
);

  localparam int AW = addr_w(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  bfiq_item_t          mem_r [FIFO_DEPTH];
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                push, pop;

  assign wr_ready = (count_r != CW'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

[rtl/bfiq_map.sv]
`default_nettype none

module bfiq_map import bfiq_pkg::*; #(
  parameter  int WORDS     = WORDS_DEF,
  parameter  int WORD_BITS = WORD_BITS_DEF,
  localparam int WORD_AW   = addr_w(WORDS),
  localparam int BIT_W     = $clog2(WORD_BITS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [IDX_W-1:0]   in_idx,
  input  wire bfiq_ctl_t          in_ctl,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WORD_AW-1:0]      out_word,
  output logic [BIT_W-1:0]        out_bit,
  output bfiq_ctl_t               out_ctl
);

  if (is_pow2(WORDS) && is_pow2(WORD_BITS)) begin : g_fast
    logic               valid_r;
    logic [WORD_AW-1:0] word_r;
    logic [BIT_W-1:0]   bit_r;
    bfiq_ctl_t          ctl_r;
    logic [WORD_AW-1:0] word_map;
    logic               load;

    if (WORDS == 1) begin : g_one_word
      assign word_map = '0;
    end else begin : g_words
      assign word_map = in_idx[BIT_W +: WORD_AW];
    end

    assign in_ready  = !valid_r || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_r;
    assign out_word  = word_r;
    assign out_bit   = bit_r;
    assign out_ctl   = ctl_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (in_ready) begin
        valid_r <= in_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        word_r <= word_map;
        bit_r  <= in_idx[BIT_W-1:0];
        ctl_r  <= in_ctl;
      end
    end

  end else begin : g_serial
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_r, state_nxt;
    logic [IDX_W-1:0]   sh_r, sh_nxt;
    logic [DIV_CW-1:0]  cnt_r, cnt_nxt;
    logic [BIT_W:0]     r1_r, r1_nxt, r1_step;
    logic [WORD_AW:0]   r2_r, r2_nxt, r2_step;
    bfiq_ctl_t          ctl_r, ctl_nxt;

    // Long division by WORD_BITS, quotient bits folded into a running
    // remainder modulo WORDS, DIV_STEPS index bits per cycle.
    always_comb begin
      logic q;
      r1_step = r1_r;
      r2_step = r2_r;
      q       = 1'b0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        r1_step = {r1_step[BIT_W-1:0], sh_r[IDX_W-1-s]};
        q       = (r1_step >= (BIT_W+1)'(WORD_BITS));
        if (q) begin
          r1_step = r1_step - (BIT_W+1)'(WORD_BITS);
        end
        r2_step = {r2_step[WORD_AW-1:0], q};
        if (r2_step >= (WORD_AW+1)'(WORDS)) begin
          r2_step = r2_step - (WORD_AW+1)'(WORDS);
        end
      end
    end

    always_comb begin
      state_nxt = state_r;
      sh_nxt    = sh_r;
      cnt_nxt   = cnt_r;
      r1_nxt    = r1_r;
      r2_nxt    = r2_r;
      ctl_nxt   = ctl_r;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sh_nxt    = in_idx;
            cnt_nxt   = '0;
            r1_nxt    = '0;
            r2_nxt    = '0;
            ctl_nxt   = in_ctl;
            state_nxt = ST_RUN;
          end
        end
        ST_RUN: begin
          sh_nxt  = sh_r << DIV_STEPS;
          r1_nxt  = r1_step;
          r2_nxt  = r2_step;
          cnt_nxt = cnt_r + DIV_CW'(1);
          if (cnt_r == DIV_CW'(DIV_CYCLES - 1)) begin
            state_nxt = ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end

    assign in_ready  = (state_r == ST_IDLE);
    assign out_valid = (state_r == ST_DONE);
    assign out_word  = r2_r[WORD_AW-1:0];
    assign out_bit   = r1_r[BIT_W-1:0];
    assign out_ctl   = ctl_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        state_r <= ST_IDLE;
      end else begin
        state_r <= state_nxt;
      end
    end

    always_ff @(posedge clk) begin
      sh_r  <= sh_nxt;
      cnt_r <= cnt_nxt;
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      ctl_r <= ctl_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bfiq_back.sv]
`default_nettype none

module bfiq_back import bfiq_pkg::*; #(
  parameter int WORDS      = WORDS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int NUM_PROBES = NUM_PROBES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire bfiq_item_t item,
  output logic            clear_busy,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_maybe_present
);

  localparam int WORD_AW = addr_w(WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int PCW     = addr_w(NUM_PROBES);

  // probe sequencer
  logic             pg_valid_r, pg_valid_nxt;
  logic             pg_query_r, pg_query_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [PCW-1:0]   pcnt_r, pcnt_nxt;
  logic             pg_last, pg_fire, pop;

  // index mapper
  logic               map_in_ready;
  logic               map_out_valid, map_out_ready;
  logic [WORD_AW-1:0] map_out_word;
  logic [BIT_W-1:0]   map_out_bit;
  bfiq_ctl_t          map_out_ctl;
  logic               rd_issue;

  // data stage
  logic               d_valid_r, d_valid_nxt;
  bfiq_ctl_t          d_ctl_r;
  logic [WORD_AW-1:0] d_word_r;
  logic [BIT_W-1:0]   d_bit_r;
  logic [WORD_BITS-1:0] cur_word, bit_mask, merged;
  logic               bit_hit, ins_wr, q_end, d_stall;
  logic               acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_data_r, out_data_nxt;

  // bit store
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 lw_valid_r;
  logic [WORD_AW-1:0]   lw_addr_r;
  logic [WORD_BITS-1:0] lw_data_r;
  logic                 clear_busy_r;
  logic [WORD_AW-1:0]   clr_addr_r;

  assign pg_last    = (pcnt_r == PCW'(NUM_PROBES - 1));
  assign pg_fire    = pg_valid_r && map_in_ready;
  assign item_ready = !pg_valid_r || (pg_fire && pg_last);
  assign pop        = item_valid && item_ready;

  always_comb begin
    pg_valid_nxt = pg_valid_r;
    pg_query_nxt = pg_query_r;
    idx_nxt      = idx_r;
    step_nxt     = step_r;
    pcnt_nxt     = pcnt_r;
    if (pop) begin
      pg_valid_nxt = 1'b1;
      pg_query_nxt = item.query;
      idx_nxt      = item.key;
      step_nxt     = item.step;
      pcnt_nxt     = '0;
    end else if (pg_fire) begin
      if (pg_last) begin
        pg_valid_nxt = 1'b0;
      end else begin
        idx_nxt  = idx_r + step_r;
        pcnt_nxt = pcnt_r + PCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_valid_r <= 1'b0;
    end else begin
      pg_valid_r <= pg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pg_query_r <= pg_query_nxt;
    idx_r      <= idx_nxt;
    step_r     <= step_nxt;
    pcnt_r     <= pcnt_nxt;
  end

  bfiq_map #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pg_valid_r),
    .in_ready  (map_in_ready),
    .in_idx    (idx_r),
    .in_ctl    ('{query: pg_query_r, last: pg_last}),
    .out_valid (map_out_valid),
    .out_ready (map_out_ready),
    .out_word  (map_out_word),
    .out_bit   (map_out_bit),
    .out_ctl   (map_out_ctl)
  );

  // Data stage: a word read last cycle may be stale by the write made at
  // the same edge, so take it from the last-write register on an address match.
  assign cur_word = (lw_valid_r && (lw_addr_r == d_word_r)) ? lw_data_r : rdata_r;
  assign bit_hit  = cur_word[d_bit_r];
  assign bit_mask = WORD_BITS'(1) << d_bit_r;
  assign merged   = cur_word | bit_mask;
  assign ins_wr   = d_valid_r && !d_ctl_r.query;
  assign q_end    = d_valid_r && d_ctl_r.query && d_ctl_r.last;
  assign d_stall  = q_end && out_valid_r && !out_ready;

  assign map_out_ready = !d_stall && !clear_busy_r;
  assign rd_issue      = map_out_valid && map_out_ready;

  always_comb begin
    d_valid_nxt   = d_stall ? d_valid_r : rd_issue;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (d_valid_r && d_ctl_r.query && !d_stall) begin
      acc_nxt = d_ctl_r.last ? 1'b1 : (acc_r & bit_hit);
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_end && !d_stall) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = acc_r & bit_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      acc_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      d_valid_r   <= d_valid_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (rd_issue) begin
      d_ctl_r  <= map_out_ctl;
      d_word_r <= map_out_word;
      d_bit_r  <= map_out_bit;
    end
  end

  // Bit store: one write and one read port, clearing pass after reset.
  assign wr_en   = clear_busy_r || ins_wr;
  assign wr_addr = clear_busy_r ? clr_addr_r : d_word_r;
  assign wr_data = clear_busy_r ? '0 : merged;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rdata_r <= mem[map_out_word];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clr_addr_r   <= '0;
      lw_valid_r   <= 1'b0;
    end else begin
      if (clear_busy_r) begin
        clr_addr_r <= clr_addr_r + WORD_AW'(1);
        if (clr_addr_r == WORD_AW'(WORDS - 1)) begin
          clear_busy_r <= 1'b0;
        end
      end
      if (wr_en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  assign clear_busy        = clear_busy_r;
  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_data_r;

  a_no_probe_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy_r |-> (!rd_issue && !d_valid_r))
    else $error("probe issued during clearing pass");

  a_stall_holds_probe: assert property (@(posedge clk) disable iff (!rst_n)
    d_stall |=> (d_valid_r && $stable(d_word_r) && $stable(d_bit_r)))
    else $error("stalled probe lost");

  a_query_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_end && !d_stall) |=> (out_valid_r && acc_r))
    else $error("query end did not post result or rearm accumulator");

  a_probe_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pg_valid_r |-> (pcnt_r <= PCW'(NUM_PROBES - 1)))
    else $error("probe counter out of range");

endmodule

`default_nettype wire
